### rtl/stbs_pkg.sv
// stbs_pkg: shared field widths, codes and controller/datapath bundles
// for the sorted table binary search block; no dependencies
package stbs_pkg;

  localparam int KIND_W       = 1;
  localparam int LOAD_INDEX_W = 10;
  localparam int KEY_W        = 32;
  localparam int CFG_W        = 11;
  localparam int MATCH_W      = 10;
  localparam int PROBE_W      = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // write the key at load_index
    logic start;    // set up a new search range and issue the first read
    logic step;     // evaluate the probed entry this cycle
    logic capture;  // park the result until the output slot frees up
    logic emit;     // load the output register
  } stbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // no entries to search
    logic hit;        // probed entry matches the key
    logic range_end;  // narrowed range is empty
    logic slot_free;  // output register can take a word
  } stbs_status_t;

endpackage

### rtl/stbs_req_if.sv
// stbs_req_if: request channel (load or search word)
// depends on stbs_pkg
interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic [stbs_pkg::KIND_W-1:0]         kind;
  logic [stbs_pkg::LOAD_INDEX_W-1:0]   load_index;
  logic [stbs_pkg::KEY_W-1:0]          key;

  modport source (output valid, kind, load_index, key, input ready);
  modport sink   (input valid, kind, load_index, key, output ready);
endinterface

### rtl/stbs_rsp_if.sv
// stbs_rsp_if: response channel (search result word)
// depends on stbs_pkg
interface stbs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [stbs_pkg::MATCH_W-1:0]     match_index;
  logic [stbs_pkg::PROBE_W-1:0]     probe_count;

  modport source (output valid, found, match_index, probe_count, input ready);
  modport sink   (input valid, found, match_index, probe_count, output ready);
endinterface

### rtl/sorted_table_binary_search.sv
// sorted_table_binary_search: top level, sorted key table with binary search
// depends on stbs_pkg, stbs_req_if, stbs_rsp_if, stbs_ctrl, stbs_datapath
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    kind, load_index, key
//   rsp      out  valid / ready    found, match_index, probe_count
//   cfg      in   cfg_we           cfg_wdata = entries_in_use
//
// a load gives no word; a search is accepted and then makes its table probes
// one at a time (up to log2(TABLE_DEPTH) + 1, 11 at the default), as set by
// the single read port of the key table
// rst is synchronous; it clears entries_in_use and the control state, the
// table contents stay undefined until loaded
// req is taken only between searches; a stalled rsp parks a finished search
// in the sequencer until the output register frees up, and req waits meanwhile
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stbs_pkg::CFG_W-1:0]  cfg_wdata,
  stbs_req_if.sink                    req,
  stbs_rsp_if.source                  rsp
);

  stbs_pkg::stbs_cmd_t    cmd;
  stbs_pkg::stbs_status_t status;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_load_index  (req.load_index),
    .req_key         (req.key),
    .cmd             (cmd),
    .status          (status),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_found       (rsp.found),
    .rsp_match_index (rsp.match_index),
    .rsp_probe_count (rsp.probe_count)
  );

endmodule

### rtl/stbs_ram.sv
// stbs_ram: generic single write port, single read port ram with registered read
// no dependencies
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/stbs_ctrl.sv
// stbs_ctrl: search sequencer state machine
// depends on stbs_pkg; drives commands into stbs_datapath
module stbs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [stbs_pkg::KIND_W-1:0]   req_kind,
  output logic                          req_ready,
  input  stbs_pkg::stbs_status_t        status,
  output stbs_pkg::stbs_cmd_t           cmd
);

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (req_valid) begin
          if (req_kind == stbs_pkg::KIND_SEARCH) begin
            cmd.start = 1'b1;
            if (status.empty) begin
              cmd.capture = 1'b1;
              state_next  = DONE;
            end else begin
              state_next  = PROBE;
            end
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      PROBE: begin
        cmd.step = 1'b1;
        if (status.hit || status.range_end) begin
          if (status.slot_free) begin
            cmd.emit   = 1'b1;
            state_next = IDLE;
          end else begin
            cmd.capture = 1'b1;
            state_next  = DONE;
          end
        end
      end
      DONE: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/stbs_datapath.sv
// stbs_datapath: key table, search range registers, compare and output register
// depends on stbs_pkg and stbs_ram
module stbs_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [stbs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [stbs_pkg::LOAD_INDEX_W-1:0]   req_load_index,
  input  logic [stbs_pkg::KEY_W-1:0]          req_key,
  input  stbs_pkg::stbs_cmd_t                 cmd,
  output stbs_pkg::stbs_status_t              status,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic                                rsp_found,
  output logic [stbs_pkg::MATCH_W-1:0]        rsp_match_index,
  output logic [stbs_pkg::PROBE_W-1:0]        rsp_probe_count
);

  localparam int KW = (KEY_WIDTH < stbs_pkg::KEY_W) ? KEY_WIDTH : stbs_pkg::KEY_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(AW + 2);

  logic [stbs_pkg::CFG_W-1:0] entries_in_use;

  logic [KW-1:0] key;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi_ex;   // exclusive upper bound of the live range
  logic [AW-1:0] mid;
  logic [PW-1:0] probes;
  logic          found_held;
  logic [AW-1:0] idx_held;

  logic [CW-1:0] n_sat;
  logic [AW-1:0] mid_first;
  logic [KW-1:0] rdata;
  logic          hit;
  logic          go_right;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW-1:0] mid_wide;
  logic [AW-1:0] mid_next;
  logic          range_end;
  logic          load_ok;
  logic [AW-1:0] raddr;
  logic          res_found;
  logic [AW-1:0] res_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
      n_sat = CW'(TABLE_DEPTH);
    end else begin
      n_sat = CW'(entries_in_use);
    end
  end

  assign mid_first = AW'((n_sat - CW'(1)) >> 1);

  // one probe per cycle: compare, narrow, and pick the next midpoint
  assign hit      = (rdata == key);
  assign go_right = (key > rdata);
  assign lo_next  = go_right ? (CW'(mid) + CW'(1)) : lo;
  assign hi_next  = go_right ? hi_ex : CW'(mid);
  assign mid_wide = lo_next + ((hi_next - lo_next - CW'(1)) >> 1);
  assign mid_next = AW'(mid_wide);
  assign range_end = !(lo_next < hi_next);

  assign load_ok = (32'(req_load_index) < 32'(TABLE_DEPTH));
  assign raddr   = cmd.start ? mid_first : mid_next;

  stbs_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (AW'(req_load_index)),
    .wdata (req_key[KW-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    status.empty     = (n_sat == '0);
    status.hit       = hit;
    status.range_end = range_end;
    status.slot_free = !rsp_valid || rsp_ready;
  end

  assign res_found = cmd.step ? hit : found_held;
  assign res_idx   = cmd.step ? (hit ? mid : '0) : idx_held;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key    <= req_key[KW-1:0];
      lo     <= '0;
      hi_ex  <= n_sat;
      mid    <= mid_first;
      probes <= (n_sat == '0) ? PW'(0) : PW'(1);
    end else if (cmd.step && !hit && !range_end) begin
      lo     <= lo_next;
      hi_ex  <= hi_next;
      mid    <= mid_next;
      probes <= probes + PW'(1);
    end
    if (cmd.capture) begin
      found_held <= cmd.step && hit;
      idx_held   <= (cmd.step && hit) ? mid : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_found       <= res_found;
      rsp_match_index <= stbs_pkg::MATCH_W'(res_idx);
      rsp_probe_count <= stbs_pkg::PROBE_W'(probes);
    end
  end

endmodule
